// File: rtl/core/smfd_pkg.sv
// ----------------------------------------------------------------------------
// smfd_pkg: measurement frame decoder definitions
// CRC-8 constants, frame layout, scaling constants and the byte decode
// helpers shared by the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package smfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [3:0]  FRAME_LAST  = 4'd8;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    localparam logic [1:0]  WORD_CO2    = 2'd0;
    localparam logic [1:0]  WORD_TEMP   = 2'd1;
    localparam logic [1:0]  WORD_HUM    = 2'd2;

    // role of a byte inside its three-byte word group
    typedef enum logic [1:0] {
        ROLE_HIGH = 2'd0,
        ROLE_LOW  = 2'd1,
        ROLE_CRC  = 2'd2
    } byte_role_t;

    typedef struct packed {
        byte_role_t role;
        logic [1:0] word;
    } pos_info_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic pos_info_t decode_pos(input logic [3:0] pos);
        pos_info_t info;
        case (pos)
            4'd0: info = '{role: ROLE_HIGH, word: WORD_CO2};
            4'd1: info = '{role: ROLE_LOW,  word: WORD_CO2};
            4'd2: info = '{role: ROLE_CRC,  word: WORD_CO2};
            4'd3: info = '{role: ROLE_HIGH, word: WORD_TEMP};
            4'd4: info = '{role: ROLE_LOW,  word: WORD_TEMP};
            4'd5: info = '{role: ROLE_CRC,  word: WORD_TEMP};
            4'd6: info = '{role: ROLE_HIGH, word: WORD_HUM};
            4'd7: info = '{role: ROLE_LOW,  word: WORD_HUM};
            default: info = '{role: ROLE_CRC, word: WORD_HUM};
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sensor_measurement_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// sensor_measurement_frame_decoder_unit: CRC-8 checked measurement decoder
// Decodes a nine-byte response (three words, each with its CRC byte) into
// CO2, temperature and humidity values with a CRC status.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and never stalls the input unless a
// finished result is still waiting downstream. Every data byte is folded
// into the running CRC and every CRC byte is checked against it in the
// cycle it is accepted; the temperature and humidity raw words are
// multiplied by their span as their low byte arrives, and the divide by full
// scale is a short add/compare done when the ninth byte is accepted. The
// result appears on the cycle after the ninth byte. s_frame_start restarts
// the frame at the current byte; a frame without it simply follows the
// previous one.
`default_nettype none

module sensor_measurement_frame_decoder_unit
    import smfd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_frame_start,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_co2_ppm,
    output logic signed [14:0]      m_temperature_centi,
    output logic [13:0]             m_humidity_centi,
    output logic                    m_status,
    output logic [1:0]              m_bad_word
);

    logic [3:0]  pos_reg,  pos_next;
    logic [7:0]  crc_reg,  crc_next;
    logic [7:0]  high_reg, high_next;
    logic        err_reg,  err_next;
    logic [1:0]  bad_reg,  bad_next;
    logic [15:0] co2_reg,  co2_next;
    logic [30:0] temp_prod_reg, temp_prod_next;
    logic [29:0] hum_prod_reg,  hum_prod_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_co2_reg,   out_co2_next;
    logic [14:0] out_temp_reg,  out_temp_next;
    logic [13:0] out_hum_reg,   out_hum_next;
    logic        out_status_reg, out_status_next;
    logic [1:0]  out_bad_reg,   out_bad_next;

    logic        in_fire;
    logic [3:0]  pos_eff;
    pos_info_t   info;
    logic        err_base;
    logic [1:0]  bad_base;
    logic        crc_fail;
    logic        frame_done;
    logic [15:0] word_now;

    // divide by 65535: x = a*2^16 + b  ->  q = a + (a + b >= 65535)
    logic [14:0] temp_a;
    logic [16:0] temp_sum;
    logic        temp_ge;
    logic [14:0] temp_q;
    logic        temp_rnz;
    logic [14:0] temp_value;
    logic [13:0] hum_a;
    logic [16:0] hum_sum;
    logic        hum_ge;
    logic [13:0] hum_q;

    assign in_fire    = s_valid && s_ready;
    assign s_ready    = !out_valid_reg || m_ready;
    assign pos_eff    = s_frame_start ? 4'd0 : pos_reg;
    assign info       = decode_pos(pos_eff);
    assign err_base   = (pos_eff == 4'd0) ? 1'b0 : err_reg;
    assign bad_base   = (pos_eff == 4'd0) ? WORD_CO2 : bad_reg;
    assign crc_fail   = (info.role == ROLE_CRC) && (s_data_byte != crc_reg);
    assign frame_done = in_fire && (pos_eff == FRAME_LAST);
    assign word_now   = {high_reg, s_data_byte};

    assign temp_a     = temp_prod_reg[30:16];
    assign temp_sum   = 17'(temp_a) + 17'(temp_prod_reg[15:0]);
    assign temp_ge    = (temp_sum >= FULL_SCALE);
    assign temp_q     = temp_a + 15'(temp_ge);
    assign temp_rnz   = (temp_sum != 17'd0) && (temp_sum != FULL_SCALE);
    // below the offset the result is negative: truncation toward zero
    // moves it up by one when the quotient was inexact
    assign temp_value = temp_q - TEMP_OFFSET
                      + 15'((temp_q < TEMP_OFFSET) && temp_rnz);

    assign hum_a      = hum_prod_reg[29:16];
    assign hum_sum    = 17'(hum_a) + 17'(hum_prod_reg[15:0]);
    assign hum_ge     = (hum_sum >= FULL_SCALE);
    assign hum_q      = hum_a + 14'(hum_ge);

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        high_next      = high_reg;
        err_next       = err_reg;
        bad_next       = bad_reg;
        co2_next       = co2_reg;
        temp_prod_next = temp_prod_reg;
        hum_prod_next  = hum_prod_reg;
        if (in_fire) begin
            pos_next = (pos_eff == FRAME_LAST) ? 4'd0 : pos_eff + 4'd1;
            err_next = err_base || crc_fail;
            bad_next = (crc_fail && !err_base) ? info.word : bad_base;
            case (info.role)
                ROLE_HIGH: begin
                    high_next = s_data_byte;
                    crc_next  = crc8_byte(CRC_INIT, s_data_byte);
                end
                ROLE_LOW: begin
                    crc_next = crc8_byte(crc_reg, s_data_byte);
                    case (info.word)
                        WORD_CO2:  co2_next = word_now;
                        WORD_TEMP: temp_prod_next = 31'(word_now) * 31'(TEMP_SPAN);
                        default:   hum_prod_next  = 30'(word_now) * 30'(HUM_SPAN);
                    endcase
                end
                default: begin
                    crc_next = CRC_INIT;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_co2_next    = out_co2_reg;
        out_temp_next   = out_temp_reg;
        out_hum_next    = out_hum_reg;
        out_status_next = out_status_reg;
        out_bad_next    = out_bad_reg;
        if (frame_done) begin
            out_valid_next  = 1'b1;
            out_status_next = err_next;
            out_bad_next    = err_next ? bad_next : WORD_CO2;
            out_co2_next    = err_next ? 16'd0 : co2_reg;
            out_temp_next   = err_next ? 15'd0 : temp_value;
            out_hum_next    = err_next ? 14'd0 : hum_q;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
            high_reg      <= 8'd0;
            err_reg       <= 1'b0;
            bad_reg       <= WORD_CO2;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            err_reg       <= err_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        co2_reg        <= co2_next;
        temp_prod_reg  <= temp_prod_next;
        hum_prod_reg   <= hum_prod_next;
        out_co2_reg    <= out_co2_next;
        out_temp_reg   <= out_temp_next;
        out_hum_reg    <= out_hum_next;
        out_status_reg <= out_status_next;
        out_bad_reg    <= out_bad_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_co2_ppm           = out_co2_reg;
    assign m_temperature_centi = $signed(out_temp_reg);
    assign m_humidity_centi    = out_hum_reg;
    assign m_status            = out_status_reg;
    assign m_bad_word          = out_bad_reg;

    // the byte count never leaves the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= FRAME_LAST)
        else $error("byte position out of frame");

    // the ninth byte of a frame always yields an item
    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> m_valid)
        else $error("frame end produced no item");

    // no item appears for a byte that does not end a frame
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!frame_done && (m_ready || !m_valid)) |=> !m_valid)
        else $error("item without frame end");

    // a failed frame carries zero values
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |->
            (m_co2_ppm == 16'd0 && m_humidity_centi == 14'd0
             && m_temperature_centi == 15'sd0 && m_bad_word != 2'd3))
        else $error("failed frame with nonzero values");

    // a good frame reports word zero and stays within the sensor range
    a_good_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status) |->
            (m_bad_word == WORD_CO2 && m_humidity_centi <= HUM_SPAN
             && m_temperature_centi >= -15'sd4500
             && m_temperature_centi <= 15'sd13000))
        else $error("good frame out of range");

endmodule

`default_nettype wire
